// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the radio control frame decoder.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define RC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== src/rcfd_pkg.sv =====
// Package for the radio control frame decoder: widths, codes, stick thresholds
// and the channel clamp function. No dependencies.
package rcfd_pkg;

  localparam int FRAME_BYTES_DEF = 32;

  localparam int POS_W   = 6;
  localparam int SUM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 16;
  localparam int CH_W    = 11;
  localparam int GOAL_W  = 13;
  localparam int TRIM_W  = 11;
  localparam int YAW_W   = 16;
  localparam int STAGE_W = 3;
  localparam int LED_W   = 2;
  localparam int LOST_W  = 10;
  localparam int IDLE_W  = 12;
  localparam int HIGH_W  = 8;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CH  = 5;
  localparam int CH_IDX_W = 3;

  localparam logic [POS_W-1:0]  POS_MAX = '1;
  localparam logic [BYTE_W-1:0] HDR0 = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR1 = 8'hAF;
  localparam logic [POS_W-1:0]  CH_FIRST_POS = 6'd4;
  localparam logic [POS_W-1:0]  CH_LAST_POS  = 6'd13;

  localparam logic [CH_W-1:0] CH_MIN     = 11'd1000;
  localparam logic [CH_W-1:0] CH_MAX     = 11'd2000;
  localparam logic [CH_W-1:0] YAW_DEC_TH = 11'd1820;
  localparam logic [CH_W-1:0] YAW_INC_TH = 11'd1180;
  localparam logic [CH_W-1:0] KILL_THR   = 11'd1050;
  localparam logic [CH_W-1:0] KILL_YAW   = 11'd1150;
  localparam logic [CH_W-1:0] LOW_THR    = 11'd1150;
  localparam logic [CH_W-1:0] HIGH_THR   = 11'd1800;
  localparam logic [CH_W-1:0] IDLE_THR   = 11'd1020;
  localparam logic [CH_W-1:0] LOW2_THR   = 11'd1100;

  localparam logic signed [GOAL_W-1:0] STICK_MID = 13'sd1500;

  localparam logic [LOST_W-1:0] LOST_LIMIT_RST = 10'd500;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 12'd3000;
  localparam logic [HIGH_W-1:0] ARM_HIGH_RST   = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOST_LIMIT = 2'd0,
    CFG_IDLE_LIMIT = 2'd1,
    CFG_ARM_HIGH   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POLL = 1'b1
  } opcode_t;

  typedef enum logic [LED_W-1:0] {
    LED_NONE  = 2'd0,
    LED_SOLID = 2'd1,
    LED_FLASH = 2'd2
  } led_t;

  typedef enum logic [STAGE_W-1:0] {
    ST_WAIT_LOW  = 3'd0,
    ST_WAIT_HIGH = 3'd1,
    ST_WAIT_LOW2 = 3'd2,
    ST_ARMING    = 3'd3,
    ST_FLYING    = 3'd4,
    ST_EXIT      = 3'd5
  } arm_stage_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [RAW_W-1:0] v);
    if (v < RAW_W'(CH_MIN)) begin
      return CH_MIN;
    end else if (v > RAW_W'(CH_MAX)) begin
      return CH_MAX;
    end else begin
      return v[CH_W-1:0];
    end
  endfunction

endpackage

// ===== src/rc_frame_decode_arming.sv =====
// Radio control frame decoder with throttle-stick arming; uses rcfd_pkg and assert_macros.svh.
// A word accepted into the input register is processed there; a poll or checksum byte leaves
// its result word in the result register. Throughput: one word per cycle, set by the single
// input register feeding one pass of logic into the result register, unless a result stalls.
// Reset (rst, synchronous, active high) restores the control and decoder state at once; the
// channel store is left as is, since every valid frame rewrites it before use.
`include "assert_macros.svh"

module rc_frame_decode_arming #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]        cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [rcfd_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              last_byte,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              frame_valid,
  output logic [rcfd_pkg::CH_W-1:0]         throttle,
  output logic signed [rcfd_pkg::GOAL_W-1:0] roll_target,
  output logic signed [rcfd_pkg::GOAL_W-1:0] pitch_target,
  output logic signed [rcfd_pkg::YAW_W-1:0] yaw_target,
  output logic                              armed,
  output logic                              hold_mode,
  output logic [rcfd_pkg::LED_W-1:0]        led_event,
  output logic                              imu_reset,
  output logic                              radio_reinit,
  output logic [rcfd_pkg::STAGE_W-1:0]      arm_stage
);
  import rcfd_pkg::*;

  // The frame is complete when the checksum byte arrives with this many bytes before it.
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // Configuration registers.
  logic [LOST_W-1:0] lost_limit;
  logic [IDLE_W-1:0] idle_limit;
  logic [HIGH_W-1:0] arm_high;

  // Input register. A word sits here while the state logic runs on it, longer if it stalls.
  logic              s1_valid;
  logic              s1_opcode;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_needs_out;
  logic              s1_fire;
  logic              in_accept;
  logic              out_free;

  // Decoder and arming state.
  logic [POS_W-1:0]  pos, pos_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic              hdr_good, hdr_good_next;
  logic [RAW_W-1:0]  chan [NUM_CH];
  arm_stage_t        stage, stage_next;
  logic [HIGH_W-1:0] high_cnt, high_cnt_next;
  logic [IDLE_W-1:0] idle_cnt, idle_cnt_next;
  logic [LOST_W-1:0] missed, missed_next;
  logic              armed_flag, armed_flag_next;
  logic              hold_flag, hold_flag_next;
  logic [CH_W-1:0]   prev_aux1, prev_aux1_next;
  logic signed [TRIM_W-1:0] roll_trim, roll_trim_next;
  logic signed [TRIM_W-1:0] pitch_trim, pitch_trim_next;
  logic signed [GOAL_W-1:0] roll_goal, roll_goal_next;
  logic signed [GOAL_W-1:0] pitch_goal, pitch_goal_next;
  logic signed [YAW_W-1:0]  yaw_goal, yaw_goal_next;
  logic [CH_W-1:0]   last_thr, last_thr_next;

  // Per-word strobes that go only to the result register.
  led_t              led;
  logic              imu;
  logic              reinit;
  logic              fvalid;

  // Channel store write decode.
  logic [POS_W-1:0]    pos_off;
  logic [CH_IDX_W-1:0] chan_idx;
  logic                chan_we;

  // Clamped channels and derived arithmetic.
  logic [CH_W-1:0]          ch_roll, ch_pitch, ch_thr, ch_yaw, ch_aux1;
  logic                     frame_ok;
  logic                     hold_tog;
  logic [LOST_W:0]          missed_inc;
  logic [HIGH_W-1:0]        high_inc;
  logic signed [GOAL_W-1:0] roll_sum, pitch_sum;
  logic signed [CH_W:0]     roll_off, pitch_off;
  arm_stage_t               stage_eff;

  // ---------------------------------------------------------------------------------------
  // Handshake. The input register empties whenever its word either makes no result or the
  // result register is free (empty, or being taken this cycle). Frame bytes therefore keep
  // entering on every cycle while a finished result still waits downstream; a poll or a
  // checksum byte then holds in the input register and stalls the input until it moves on.
  // ---------------------------------------------------------------------------------------
  assign out_free     = !out_valid || !out_stall;
  assign s1_needs_out = (s1_opcode == OP_POLL) || s1_last;
  assign s1_fire      = s1_valid && (!s1_needs_out || out_free);
  assign in_stall     = s1_valid && !s1_fire;
  assign in_accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode <= opcode;
      s1_byte   <= data_byte;
      s1_last   <= last_byte;
    end
  end

  // Configuration writes land at once; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_limit <= LOST_LIMIT_RST;
      idle_limit <= IDLE_LIMIT_RST;
      arm_high   <= ARM_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOST_LIMIT: lost_limit <= cfg_data[LOST_W-1:0];
        CFG_IDLE_LIMIT: idle_limit <= cfg_data[IDLE_W-1:0];
        CFG_ARM_HIGH:   arm_high   <= cfg_data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Channel store. Bytes 4 to 13 carry roll, pitch, throttle, yaw and aux1 as big-endian
  // 16-bit values; the remaining aux channels are not kept. A valid frame always rewrites
  // every kept channel, so the store needs no reset.
  // ---------------------------------------------------------------------------------------
  assign pos_off  = pos - CH_FIRST_POS;
  assign chan_idx = pos_off[CH_IDX_W:1];
  assign chan_we  = s1_fire && (s1_opcode == OP_BYTE) && !s1_last &&
                    (pos >= CH_FIRST_POS) && (pos <= CH_LAST_POS);

  always_ff @(posedge clk) begin
    if (chan_we) begin
      if (!pos[0]) begin
        chan[chan_idx][RAW_W-1:BYTE_W] <= s1_byte;
      end else begin
        chan[chan_idx][BYTE_W-1:0] <= s1_byte;
      end
    end
  end

  assign ch_roll  = clamp_ch(chan[0]);
  assign ch_pitch = clamp_ch(chan[1]);
  assign ch_thr   = clamp_ch(chan[2]);
  assign ch_yaw   = clamp_ch(chan[3]);
  assign ch_aux1  = clamp_ch(chan[4]);

  // Frame check on the checksum byte.
  assign frame_ok = hdr_good && (pos == LAST_POS) && (sum == s1_byte);

  // A change of aux1 toggles hold mode; this toggled value is what the rest of the frame sees.
  assign hold_tog = (ch_aux1 != prev_aux1) ? !hold_flag : hold_flag;

  // Attitude targets: (1500 - stick + trim) fits 11 bits signed, times four fits 13 bits.
  assign roll_sum  = STICK_MID - $signed({2'b00, ch_roll}) + GOAL_W'(roll_trim);
  assign pitch_sum = STICK_MID - $signed({2'b00, ch_pitch}) + GOAL_W'(pitch_trim);

  // Trim captured at arming is stick minus center, within plus or minus 500.
  assign roll_off  = $signed({1'b0, ch_roll}) - (CH_W+1)'(STICK_MID);
  assign pitch_off = $signed({1'b0, ch_pitch}) - (CH_W+1)'(STICK_MID);

  assign missed_inc = {1'b0, missed} + (LOST_W+1)'(1);
  assign high_inc   = high_cnt + HIGH_W'(1);

  // Throttle fully down with yaw hard over forces the exit stage before the machine runs.
  assign stage_eff = ((ch_thr < KILL_THR) && (ch_yaw < KILL_YAW)) ? ST_EXIT : stage;

  // ---------------------------------------------------------------------------------------
  // State update for the word in the input register.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    pos_next        = pos;
    sum_next        = sum;
    hdr_good_next   = hdr_good;
    stage_next      = stage;
    high_cnt_next   = high_cnt;
    idle_cnt_next   = idle_cnt;
    missed_next     = missed;
    armed_flag_next = armed_flag;
    hold_flag_next  = hold_flag;
    prev_aux1_next  = prev_aux1;
    roll_trim_next  = roll_trim;
    pitch_trim_next = pitch_trim;
    roll_goal_next  = roll_goal;
    pitch_goal_next = pitch_goal;
    yaw_goal_next   = yaw_goal;
    last_thr_next   = last_thr;
    led             = LED_NONE;
    imu             = 1'b0;
    reinit          = 1'b0;
    fvalid          = 1'b0;

    if (s1_fire) begin
      if (s1_opcode == OP_POLL) begin
        // A poll with no frame drops any partial frame and counts toward link loss.
        pos_next      = '0;
        sum_next      = '0;
        hdr_good_next = 1'b1;
        if (missed_inc > {1'b0, lost_limit}) begin
          missed_next     = '0;
          armed_flag_next = 1'b0;
          reinit          = 1'b1;
        end else begin
          missed_next = missed_inc[LOST_W-1:0];
        end
      end else if (!s1_last) begin
        if ((pos == POS_W'(0)) && (s1_byte != HDR0)) begin
          hdr_good_next = 1'b0;
        end
        if ((pos == POS_W'(1)) && (s1_byte != HDR1)) begin
          hdr_good_next = 1'b0;
        end
        sum_next = sum + s1_byte;
        // The position stops at its top value; an overlong frame is marked bad.
        if (pos == POS_MAX) begin
          hdr_good_next = 1'b0;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end else begin
        missed_next   = '0;
        fvalid        = frame_ok;
        pos_next      = '0;
        sum_next      = '0;
        hdr_good_next = 1'b1;
        if (frame_ok) begin
          last_thr_next  = ch_thr;
          prev_aux1_next = ch_aux1;
          hold_flag_next = hold_tog;
          if (!hold_tog) begin
            roll_goal_next  = {roll_sum[GOAL_W-3:0], 2'b00};
            pitch_goal_next = {pitch_sum[GOAL_W-3:0], 2'b00};
          end
          if (ch_yaw > YAW_DEC_TH) begin
            if (yaw_goal != {1'b1, {(YAW_W-1){1'b0}}}) begin
              yaw_goal_next = yaw_goal - YAW_W'(1);
            end
          end else if (ch_yaw < YAW_INC_TH) begin
            if (yaw_goal != {1'b0, {(YAW_W-1){1'b1}}}) begin
              yaw_goal_next = yaw_goal + YAW_W'(1);
            end
          end

          case (stage_eff)
            ST_WAIT_LOW: begin
              if (ch_thr < LOW_THR) begin
                stage_next = ST_WAIT_HIGH;
              end
            end
            ST_WAIT_HIGH: begin
              if (ch_thr > HIGH_THR) begin
                if (high_inc > arm_high) begin
                  high_cnt_next = '0;
                  stage_next    = ST_WAIT_LOW2;
                end else begin
                  high_cnt_next = high_inc;
                end
              end
            end
            ST_WAIT_LOW2: begin
              if (ch_thr < LOW2_THR) begin
                stage_next = ST_ARMING;
              end
            end
            ST_ARMING: begin
              armed_flag_next = 1'b1;
              stage_next      = ST_FLYING;
              led             = LED_SOLID;
              prev_aux1_next  = ch_aux1;
              hold_flag_next  = 1'b0;
              roll_trim_next  = roll_off[TRIM_W-1:0];
              pitch_trim_next = pitch_off[TRIM_W-1:0];
              imu             = 1'b1;
            end
            ST_FLYING: begin
              if (ch_thr < IDLE_THR) begin
                // Idle disarm counts only outside hold mode; the old count is compared.
                if (!hold_tog) begin
                  if (idle_cnt != '1) begin
                    idle_cnt_next = idle_cnt + IDLE_W'(1);
                  end
                  if (idle_cnt > idle_limit) begin
                    stage_next = ST_EXIT;
                  end
                end
              end else if (!armed_flag) begin
                stage_next = ST_EXIT;
              end else begin
                idle_cnt_next = '0;
              end
            end
            ST_EXIT: begin
              led             = LED_FLASH;
              idle_cnt_next   = '0;
              armed_flag_next = 1'b0;
              stage_next      = ST_WAIT_LOW;
            end
            default: begin
              stage_next = ST_EXIT;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      sum        <= '0;
      hdr_good   <= 1'b1;
      stage      <= ST_WAIT_LOW;
      high_cnt   <= '0;
      idle_cnt   <= '0;
      missed     <= '0;
      armed_flag <= 1'b0;
      hold_flag  <= 1'b0;
      prev_aux1  <= CH_MIN;
      roll_trim  <= '0;
      pitch_trim <= '0;
      roll_goal  <= '0;
      pitch_goal <= '0;
      yaw_goal   <= '0;
      last_thr   <= CH_MIN;
    end else begin
      pos        <= pos_next;
      sum        <= sum_next;
      hdr_good   <= hdr_good_next;
      stage      <= stage_next;
      high_cnt   <= high_cnt_next;
      idle_cnt   <= idle_cnt_next;
      missed     <= missed_next;
      armed_flag <= armed_flag_next;
      hold_flag  <= hold_flag_next;
      prev_aux1  <= prev_aux1_next;
      roll_trim  <= roll_trim_next;
      pitch_trim <= pitch_trim_next;
      roll_goal  <= roll_goal_next;
      pitch_goal <= pitch_goal_next;
      yaw_goal   <= yaw_goal_next;
      last_thr   <= last_thr_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result register. Polls and checksum bytes each leave one word holding the updated state.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_needs_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_needs_out) begin
      frame_valid  <= fvalid;
      throttle     <= last_thr_next;
      roll_target  <= roll_goal_next;
      pitch_target <= pitch_goal_next;
      yaw_target   <= yaw_goal_next;
      armed        <= armed_flag_next;
      hold_mode    <= hold_flag_next;
      led_event    <= led;
      imu_reset    <= imu;
      radio_reinit <= reinit;
      arm_stage    <= stage_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  // Motors are only unlocked while flying or on the way out of flight.
  `RC_ASSERT_IMP(a_armed_stage, clk, rst, armed_flag, (stage == ST_FLYING) || (stage == ST_EXIT))
  // The estimator reset word is the arming word itself.
  `RC_ASSERT_IMP(a_imu_on_arm, clk, rst, out_valid && imu_reset,
                 armed && (led_event == LED_SOLID) && (arm_stage == ST_FLYING))
  // A link-loss word never carries a frame and always shows the block disarmed.
  `RC_ASSERT_IMP(a_reinit_disarm, clk, rst, out_valid && radio_reinit, !armed && !frame_valid)
  // An accepted word is held in the input register on the following cycle.
  `RC_ASSERT_NXT(a_in_capture, clk, rst, in_accept, s1_valid)

endmodule
